// ===== hdl/lsfx_pkg.sv =====
// Package for the LED strip effect generator.
// Holds mode codes, datapath commands, the config and status structs and the colour helpers.
// No dependencies.
package lsfx_pkg;

  localparam int unsigned LedCountDef = 71;
  localparam logic [31:0] LfsrPoly    = 32'h04C1_1DB7;
  localparam logic [31:0] NoiseSeed   = 32'd64738;
  localparam logic [9:0]  HueSteps    = 10'd768;
  localparam logic [7:0]  KeyShiftLock = 8'h41;
  localparam logic [9:0]  SparkleNone = 10'h0FF;
  localparam logic [6:0]  SparkleInten = 7'h7F;

  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_FIXED   = 3'd1;
  localparam logic [2:0] MODE_SID     = 3'd2;
  localparam logic [2:0] MODE_RAINBOW = 3'd3;
  localparam logic [2:0] MODE_SPARKLE = 3'd4;

  localparam logic [1:0] KIND_LED   = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_LOCK  = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_BRIGHT = 2'd1;
  localparam logic [1:0] REG_HUE    = 2'd2;
  localparam logic [1:0] REG_TINT   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_START,
    OP_COLOUR,
    OP_MIXA_FADE,
    OP_MIXA_TINT,
    OP_MIXB,
    OP_SCALE,
    OP_EMIT_KEY,
    OP_EMIT_MAIN,
    OP_READ,
    OP_EMIT_RESTORE,
    OP_STEP_LFSR,
    OP_EMIT_WHITE,
    OP_EMIT_END
  } lsfx_op_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] bright;
    logic [4:0] hue;
    logic [1:0] tint;
  } lsfx_cfg_t;

  typedef struct packed {
    lsfx_op_e op;
  } lsfx_cmd_t;

  typedef struct packed {
    logic out_full;
    logic key_hit;
    logic fade_nz;
    logic spk_hit;
    logic rnd_hit;
    logic clr_last;
  } lsfx_stat_t;

  typedef struct packed {
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
  } lsfx_rgb_t;

  function automatic logic [7:0] tint_amount(input logic [1:0] lvl);
    logic [7:0] v;
    unique case (lvl)
      2'd0: v = 8'd0;
      2'd1: v = 8'd50;
      2'd2: v = 8'd100;
      default: v = 8'd170;
    endcase
    return v;
  endfunction

  function automatic lsfx_rgb_t hue_colour(input logic [10:0] h);
    lsfx_rgb_t c;
    logic [7:0] f;
    f = h[7:0];
    unique case (h[10:8])
      3'd0: c = '{g: f,         r: 8'hFF,      b: 8'h00};
      3'd1: c = '{g: 8'hFF,     r: 8'hFF - f,  b: 8'h00};
      3'd2: c = '{g: 8'hFF,     r: 8'h00,      b: f};
      3'd3: c = '{g: 8'hFF - f, r: 8'h00,      b: 8'hFF};
      3'd4: c = '{g: 8'h00,     r: f,          b: 8'hFF};
      default: c = '{g: 8'h00,  r: 8'hFF,      b: 8'hFF - f};
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/lsfx_ctrl.sv =====
// Sequencer of the LED strip effect generator.
// Steps each tick through colour build, mixes and result writes; uses lsfx_pkg.
module lsfx_ctrl import lsfx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lsfx_stat_t stat_i,
  output lsfx_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_KEY  = 4'd2;
  localparam logic [3:0] S_COL  = 4'd3;
  localparam logic [3:0] S_FMA  = 4'd4;
  localparam logic [3:0] S_FMB  = 4'd5;
  localparam logic [3:0] S_TMA  = 4'd6;
  localparam logic [3:0] S_TMB  = 4'd7;
  localparam logic [3:0] S_SCL  = 4'd8;
  localparam logic [3:0] S_E0   = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_E1   = 4'd11;
  localparam logic [3:0] S_LF   = 4'd12;
  localparam logic [3:0] S_E2   = 4'd13;
  localparam logic [3:0] S_E3   = 4'd14;

  logic [3:0] state_q, state_d;
  logic       rainbow, sparkle;

  assign rainbow = (mode_i == MODE_RAINBOW) || (mode_i == MODE_SPARKLE);
  assign sparkle = (mode_i == MODE_SPARKLE);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        if (!stat_i.key_hit) begin
          state_d = S_COL;
        end else if (!stat_i.out_full) begin
          cmd_o.op = OP_EMIT_KEY;
          state_d = S_COL;
        end
      end
      S_COL: begin
        cmd_o.op = OP_COLOUR;
        if (rainbow && stat_i.fade_nz) state_d = S_FMA;
        else if (rainbow || mode_i == MODE_FIXED) state_d = S_TMA;
        else state_d = S_E0;
      end
      S_FMA: begin
        cmd_o.op = OP_MIXA_FADE;
        state_d = S_FMB;
      end
      S_FMB: begin
        cmd_o.op = OP_MIXB;
        state_d = S_TMA;
      end
      S_TMA: begin
        cmd_o.op = OP_MIXA_TINT;
        state_d = S_TMB;
      end
      S_TMB: begin
        cmd_o.op = OP_MIXB;
        state_d = sparkle ? S_SCL : S_E0;
      end
      S_SCL: begin
        cmd_o.op = OP_SCALE;
        state_d = S_E0;
      end
      S_E0: begin
        if (!stat_i.out_full) begin
          cmd_o.op = OP_EMIT_MAIN;
          if (!sparkle) state_d = S_E3;
          else if (stat_i.spk_hit) state_d = S_RD;
          else state_d = S_LF;
        end
      end
      S_RD: begin
        cmd_o.op = OP_READ;
        state_d = S_E1;
      end
      S_E1: begin
        if (!stat_i.out_full) begin
          cmd_o.op = OP_EMIT_RESTORE;
          state_d = S_LF;
        end
      end
      S_LF: begin
        cmd_o.op = OP_STEP_LFSR;
        state_d = S_E2;
      end
      S_E2: begin
        if (!stat_i.rnd_hit) begin
          state_d = S_E3;
        end else if (!stat_i.out_full) begin
          cmd_o.op = OP_EMIT_WHITE;
          state_d = S_E3;
        end
      end
      S_E3: begin
        if (!stat_i.out_full) begin
          cmd_o.op = OP_EMIT_END;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/lsfx_dp.sv =====
// Datapath of the LED strip effect generator.
// Holds effect state, colour mixer, noise register, backup memory and result register; uses lsfx_pkg.
module lsfx_dp import lsfx_pkg::*; #(
  parameter int unsigned LED_COUNT = LedCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lsfx_cfg_t  cfg_i,
  input  lsfx_cmd_t  cmd_i,
  output lsfx_stat_t stat_o,
  input  logic [33:0] in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [6:0] out_led_o,
  output lsfx_rgb_t  out_rgb_o,
  output logic [6:0] out_inten_o,
  output logic       out_last_o
);

  localparam int unsigned IdxW = $clog2(LED_COUNT);
  localparam logic [10:0] Count = 11'(LED_COUNT);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(LED_COUNT - 1);

  logic [33:0]     in_q;
  logic [9:0]      hue_q;
  logic [7:0]      fade_q, fade_t_q;
  logic [IdxW-1:0] ring_q, pos_q, clr_q;
  logic [31:0]     lfsr_q;
  logic [9:0]      spk_q;
  lsfx_rgb_t       c_q, rd_q;
  logic [15:0]     x_q [3];
  lsfx_rgb_t       mem [LED_COUNT];

  logic        out_vld_q, out_last_q;
  logic [1:0]  out_kind_q;
  logic [6:0]  out_led_q, out_inten_q;
  lsfx_rgb_t   out_rgb_q;

  logic        sparkle, fixed_mode, anim;
  logic [10:0] hue_sum;
  logic [9:0]  hue_nxt;
  lsfx_rgb_t   base_c;
  logic [7:0]  mix_t;
  logic [7:0]  c_in [3];
  logic [7:0]  c_mb [3];
  logic [7:0]  c_sc [3];
  logic        emit;

  assign sparkle    = (cfg_i.mode == MODE_SPARKLE);
  assign fixed_mode = (cfg_i.mode == MODE_FIXED);
  assign anim       = (cfg_i.mode == MODE_RAINBOW) || sparkle;

  assign hue_sum = {1'b0, hue_q} + (sparkle ? 11'd10 : 11'd1);
  assign hue_nxt = (hue_sum >= {1'b0, HueSteps}) ? 10'(hue_sum - {1'b0, HueSteps})
                                                  : hue_sum[9:0];

  always_comb begin
    unique case (cfg_i.mode)
      MODE_FIXED:
        base_c = (cfg_i.hue == 5'd24) ? '{g: 8'hFF, r: 8'hFF, b: 8'hFF}
                                       : hue_colour({cfg_i.hue, 6'b0});
      MODE_SID:     base_c = '{g: in_q[17:10], r: in_q[25:18], b: in_q[33:26]};
      MODE_RAINBOW: base_c = hue_colour({hue_nxt, 1'b0});
      MODE_SPARKLE: base_c = hue_colour({hue_nxt, 1'b0});
      default:      base_c = '0;
    endcase
  end

  assign mix_t = (cmd_i.op == OP_MIXA_FADE) ? fade_t_q : tint_amount(cfg_i.tint);
  assign c_in[0] = c_q.g;
  assign c_in[1] = c_q.r;
  assign c_in[2] = c_q.b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] p;
      logic [12:0] s;
      p = {16'b0, x_q[i]} * 32'h0000_8081;
      c_mb[i] = p[30:23];
      s = {5'b0, c_in[i]} * {8'b0, cfg_i.bright};
      c_sc[i] = s[12:5];
    end
  end

  assign emit = (cmd_i.op == OP_EMIT_KEY) || (cmd_i.op == OP_EMIT_MAIN) ||
                (cmd_i.op == OP_EMIT_RESTORE) || (cmd_i.op == OP_EMIT_WHITE) ||
                (cmd_i.op == OP_EMIT_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q     <= '0;
      fade_q    <= 8'd255;
      ring_q    <= '0;
      lfsr_q    <= NoiseSeed;
      spk_q     <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      if (emit) out_vld_q <= 1'b1;
      unique case (cmd_i.op)
        OP_CLEAR: clr_q <= clr_q + 1'b1;
        OP_COLOUR: begin
          if (anim) begin
            hue_q <= hue_nxt;
            if (fade_q != 8'd0) fade_q <= fade_q - (sparkle ? 8'd15 : 8'd1);
          end
          if (cfg_i.mode == MODE_OFF || fixed_mode || cfg_i.mode > MODE_SPARKLE) begin
            ring_q <= '0;
          end else begin
            ring_q <= (ring_q == '0) ? LastIdx : ring_q - 1'b1;
          end
        end
        OP_EMIT_RESTORE: spk_q <= SparkleNone;
        OP_STEP_LFSR: begin
          lfsr_q <= lfsr_q[31] ? ({lfsr_q[30:0], 1'b0} ^ LfsrPoly) : {lfsr_q[30:0], 1'b0};
        end
        OP_EMIT_WHITE: spk_q <= lfsr_q[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_START: in_q <= in_data_i;
      OP_COLOUR: begin
        c_q      <= base_c;
        fade_t_q <= fade_q;
        pos_q    <= (anim || cfg_i.mode == MODE_SID) ? ring_q : '0;
      end
      OP_MIXA_FADE, OP_MIXA_TINT: begin
        for (int i = 0; i < 3; i++) begin
          x_q[i] <= 16'({8'b0, c_in[i]} * (16'd255 - {8'b0, mix_t}) +
                        16'd255 * {8'b0, mix_t} + 16'd127);
        end
      end
      OP_MIXB:  c_q <= '{g: c_mb[0], r: c_mb[1], b: c_mb[2]};
      OP_SCALE: c_q <= '{g: c_sc[0], r: c_sc[1], b: c_sc[2]};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR) mem[clr_q] <= '0;
    else if (cmd_i.op == OP_EMIT_MAIN && sparkle) mem[pos_q] <= c_q;
    if (cmd_i.op == OP_READ) rd_q <= mem[spk_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q  <= KIND_LED;
      out_led_q   <= '0;
      out_rgb_q   <= '0;
      out_inten_q <= '0;
      out_last_q  <= 1'b0;
      unique case (cmd_i.op)
        OP_EMIT_KEY: begin
          out_kind_q <= KIND_LOCK;
          if (in_q[9]) out_rgb_q <= '{g: 8'hA0, r: 8'hC0, b: 8'h00};
        end
        OP_EMIT_MAIN: begin
          out_led_q <= 7'(pos_q);
          out_rgb_q <= c_q;
        end
        OP_EMIT_RESTORE: begin
          out_led_q <= spk_q[6:0];
          out_rgb_q <= rd_q;
        end
        OP_EMIT_WHITE: begin
          out_led_q <= lfsr_q[6:0];
          out_rgb_q <= '{g: 8'hFF, r: 8'hFF, b: 8'hFF};
        end
        default: begin
          out_kind_q  <= KIND_START;
          out_led_q   <= 7'(pos_q);
          out_inten_q <= sparkle ? SparkleInten : {cfg_i.bright, 2'b00};
          out_last_q  <= 1'b1;
        end
      endcase
    end
  end

  assign stat_o.out_full = out_vld_q;
  assign stat_o.key_hit  = in_q[0] && (in_q[8:1] == KeyShiftLock);
  assign stat_o.fade_nz  = (fade_q != 8'd0);
  assign stat_o.spk_hit  = ({1'b0, spk_q} < Count);
  assign stat_o.rnd_hit  = ({1'b0, lfsr_q[9:0]} < Count);
  assign stat_o.clr_last = (clr_q == LastIdx);

  assign out_valid_o = out_vld_q;
  assign out_kind_o  = out_kind_q;
  assign out_led_o   = out_led_q;
  assign out_rgb_o   = out_rgb_q;
  assign out_inten_o = out_inten_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/led_strip_effect_generator_core.sv =====
// One tick in flight: s_axis_tready rises as the last result word of a tick is loaded into
// the output register, and stalls on m_axis_tready hold the sequencer at each result word.
// The sequencer in lsfx_ctrl steps through the colour build, the colour mixes and the word writes.
// Reset: asynchronous, active low; after reset the backup memory is cleared entry by entry
// while s_axis_tready stays low. Write config only between ticks.
module led_strip_effect_generator_core import lsfx_pkg::*; #(
  parameter int unsigned LED_COUNT = LedCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_valid, key_code[8], lock_active, voice_one_env, voice_two_env, voice_three_env
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // led_index[7], green_level, red_level, blue_level, strip_intensity[7]
  output logic [39:0] m_axis_tdata,
  // write_kind[2]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] mode_q;
  logic [4:0] bright_q, hue_q;
  logic [1:0] tint_q;
  lsfx_cfg_t  cfg;
  lsfx_cmd_t  cmd;
  lsfx_stat_t stat;
  lsfx_rgb_t  rgb;
  logic [6:0] led, inten;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RAINBOW;
      bright_q <= 5'd9;
      hue_q    <= 5'd15;
      tint_q   <= 2'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MODE:   mode_q   <= pwdata[2:0];
        REG_BRIGHT: bright_q <= pwdata[4:0];
        REG_HUE:    hue_q    <= pwdata[4:0];
        default:    tint_q   <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = {29'b0, mode_q};
      REG_BRIGHT: prdata = {27'b0, bright_q};
      REG_HUE:    prdata = {27'b0, hue_q};
      default:    prdata = {30'b0, tint_q};
    endcase
  end

  assign cfg.mode   = (mode_q > MODE_SPARKLE) ? MODE_OFF : mode_q;
  assign cfg.bright = bright_q;
  assign cfg.hue    = hue_q;
  assign cfg.tint   = tint_q;

  lsfx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (cfg.mode),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsfx_dp #(.LED_COUNT(LED_COUNT)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata[33:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_led_o   (led),
    .out_rgb_o   (rgb),
    .out_inten_o (inten),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b0, inten, rgb.b, rgb.r, rgb.g, led};

endmodule

// ===== verif/led_strip_effect_generator_core_chk.sv =====
// Scoreboard for the LED strip effect generator: snoops config writes and both streams,
// predicts the result words of every accepted tick and compares them in order.
// Depends on lsfx_pkg for mode, kind and register codes.
module led_strip_effect_generator_core_chk import lsfx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // key_valid, key_code[8], lock_active, voice_one_env, voice_two_env, voice_three_env
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // led_index[7], green_level, red_level, blue_level, strip_intensity[7]
  input  logic [39:0] m_axis_tdata,
  // write_kind[2]
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumLeds = LedCountDef;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] led;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
    logic [6:0] inten;
    logic       last;
  } led_word_t;

  typedef struct {
    int unsigned r, g, b;
  } pixel_t;

  led_word_t  strip_words_q[$];
  logic [2:0] mode_q;
  logic [4:0] bright_q;
  logic [4:0] hue_q;
  logic [1:0] tint_q;
  int unsigned hue_pos, fade, ring_pos, sparkle_idx;
  logic [31:0] noise;
  pixel_t     backup[NumLeds];
  int         fails;

  assign fail_count_o = fails;

  function automatic int unsigned mix(int unsigned a, int unsigned b, int unsigned t);
    return (a * (255 - t) + b * t + 127) / 255;
  endfunction

  function automatic pixel_t toward_white(pixel_t c, int unsigned t);
    pixel_t o;
    o.r = mix(c.r, 255, t);
    o.g = mix(c.g, 255, t);
    o.b = mix(c.b, 255, t);
    return o;
  endfunction

  function automatic pixel_t hue_pixel(int unsigned idx, int unsigned steps);
    int unsigned h, f;
    pixel_t c;
    h = idx * 1536 / steps;
    f = h % 256;
    case (h / 256)
      0: c = '{255, f, 0};
      1: c = '{255 - f, 255, 0};
      2: c = '{0, 255, f};
      3: c = '{0, 255 - f, 255};
      4: c = '{f, 0, 255};
      default: c = '{255, 0, 255 - f};
    endcase
    return c;
  endfunction

  function automatic int unsigned tint_of(logic [1:0] lvl);
    case (lvl)
      2'd0: return 0;
      2'd1: return 50;
      2'd2: return 100;
      default: return 170;
    endcase
  endfunction

  function automatic int unsigned ring_step(int unsigned p);
    return (p == 0 || p >= NumLeds) ? NumLeds - 1 : p - 1;
  endfunction

  task automatic push_word(logic [1:0] kind, int unsigned led, pixel_t c, int unsigned inten);
    led_word_t w;
    w.kind  = kind;
    w.led   = led[6:0];
    w.g     = c.g[7:0];
    w.r     = c.r[7:0];
    w.b     = c.b[7:0];
    w.inten = inten[6:0];
    w.last  = 1'b0;
    strip_words_q.push_back(w);
  endtask

  task automatic predict_tick(logic [39:0] d);
    pixel_t blk, wht, c;
    logic [2:0] mode;
    int unsigned inten, tint, pos, rnd;
    blk   = '{0, 0, 0};
    wht   = '{255, 255, 255};
    mode  = (mode_q > MODE_SPARKLE) ? MODE_OFF : mode_q;
    inten = bright_q * 4;
    tint  = tint_of(tint_q);
    if (d[0] && d[8:1] == KeyShiftLock) begin
      c = blk;
      if (d[9]) c = '{8'hC0, 8'hA0, 0};
      push_word(KIND_LOCK, 0, c, 0);
    end
    case (mode)
      MODE_FIXED: begin
        ring_pos = 0;
        c = (hue_q == 24) ? wht : hue_pixel(hue_q, 24);
        c = toward_white(c, tint);
        push_word(KIND_LED, 0, c, 0);
        push_word(KIND_START, 0, blk, inten);
      end
      MODE_SID: begin
        pos = ring_pos;
        c.g = d[17:10];
        c.r = d[25:18];
        c.b = d[33:26];
        push_word(KIND_LED, pos, c, 0);
        push_word(KIND_START, pos, blk, inten);
        ring_pos = ring_step(pos);
      end
      MODE_RAINBOW: begin
        hue_pos = (hue_pos + 1) % 768;
        c = hue_pixel(hue_pos, 768);
        if (fade != 0) begin
          c = toward_white(c, fade);
          fade = (fade - 1) & 8'hFF;
        end
        c = toward_white(c, tint);
        pos = ring_pos;
        push_word(KIND_LED, pos, c, 0);
        push_word(KIND_START, pos, blk, inten);
        ring_pos = ring_step(pos);
      end
      MODE_SPARKLE: begin
        hue_pos = hue_pos + 10;
        if (hue_pos >= 768) hue_pos -= 768;
        c = hue_pixel(hue_pos, 768);
        if (fade != 0) begin
          c = toward_white(c, fade);
          fade = (fade - 15) & 8'hFF;
        end
        c = toward_white(c, tint);
        c.r = (c.r * bright_q) >> 5;
        c.g = (c.g * bright_q) >> 5;
        c.b = (c.b * bright_q) >> 5;
        pos = ring_pos;
        if (pos < NumLeds) backup[pos] = c;
        push_word(KIND_LED, pos, c, 0);
        ring_pos = ring_step(pos);
        if (sparkle_idx < NumLeds) begin
          push_word(KIND_LED, sparkle_idx, backup[sparkle_idx], 0);
          sparkle_idx = 8'hFF;
        end
        noise = noise[31] ? ((noise << 1) ^ LfsrPoly) : (noise << 1);
        rnd = noise[9:0];
        if (rnd < NumLeds) begin
          sparkle_idx = rnd;
          push_word(KIND_LED, rnd, wht, 0);
        end
        push_word(KIND_START, pos, blk, SparkleInten);
      end
      default: begin
        ring_pos = 0;
        push_word(KIND_LED, 0, blk, 0);
        push_word(KIND_START, 0, blk, inten);
      end
    endcase
    strip_words_q[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    led_word_t got, want;
    if (!rst_ni) begin
      strip_words_q.delete();
      mode_q      <= MODE_RAINBOW;
      bright_q    <= 5'd9;
      hue_q       <= 5'd15;
      tint_q      <= 2'd0;
      hue_pos     = 0;
      fade        = 255;
      ring_pos    = 0;
      noise       = NoiseSeed;
      sparkle_idx = 0;
      fails       = 0;
      foreach (backup[i]) backup[i] = '{0, 0, 0};
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE:   mode_q   <= pwdata[2:0];
          REG_BRIGHT: bright_q <= pwdata[4:0];
          REG_HUE:    hue_q    <= pwdata[4:0];
          default:    tint_q   <= pwdata[1:0];
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[14:7], m_axis_tdata[22:15],
               m_axis_tdata[30:23], m_axis_tdata[37:31], m_axis_tlast};
        if (strip_words_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word, expected none, actual %h", $realtime, got);
        end else begin
          want = strip_words_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch kind/led/g/r/b/int/last expected %h %h %h %h %h %h %b",
                     $realtime, want.kind, want.led, want.g, want.r, want.b, want.inten,
                     want.last);
            $display("%0t:                                 actual   %h %h %h %h %h %h %b",
                     $realtime, got.kind, got.led, got.g, got.r, got.b, got.inten,
                     got.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_tick(s_axis_tdata);
    end
    pending_o = strip_words_q.size();
  end

endmodule

// ===== verif/led_strip_effect_generator_core_tb.sv =====
// Top of the LED strip effect generator bench: clock, reset, APB config and tick stimulus.
// Depends on lsfx_pkg, the core and led_strip_effect_generator_core_chk for checking.
module led_strip_effect_generator_core_tb import lsfx_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // key_valid, key_code[8], lock_active, voice_one_env, voice_two_env, voice_three_env
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // led_index[7], green_level, red_level, blue_level, strip_intensity[7]
  logic [39:0] m_axis_tdata;
  // write_kind[2]
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  led_strip_effect_generator_core dut (.*);

  led_strip_effect_generator_core_chk u_chk (
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .*
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Sink side: random ready with one long hold-off.
  initial begin
    int unsigned cyc;
    int unsigned n;
    m_axis_tready = 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (n) @(posedge clk_i);
      cyc += n;
      if (cyc > 3000 && cyc < 3100) n = 400;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 60);
      else if ($urandom_range(0, 2) == 0) n = 0;
      else n = $urandom_range(1, 3);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        cyc += n;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_effect(logic [2:0] mode, logic [4:0] bright, logic [4:0] hue,
                            logic [1:0] tint);
    drain();
    reg_write(REG_MODE, {29'd0, mode});
    reg_write(REG_BRIGHT, {27'd0, bright});
    reg_write(REG_HUE, {27'd0, hue});
    reg_write(REG_TINT, {30'd0, tint});
  endtask

  task automatic send_tick(logic kv, logic [7:0] code, logic lock,
                           logic [7:0] v1, logic [7:0] v2, logic [7:0] v3);
    logic ok;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, v3, v2, v1, lock, code, kv};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    if ($urandom_range(0, 3) == 0) gap = 0;
    else if ($urandom_range(0, 11) == 0) gap = $urandom_range(20, 80);
    else gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_tick;
    logic [7:0] v[3];
    int unsigned sel;
    foreach (v[i]) begin
      sel = $urandom_range(0, 9);
      v[i] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
    end
    if ($urandom_range(0, 3) == 0)
      send_tick(1'b1, KeyShiftLock, 1'($urandom), v[0], v[1], v[2]);
    else
      send_tick(1'($urandom), 8'($urandom), 1'($urandom), v[0], v[1], v[2]);
  endtask

  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(1'b1, KeyShiftLock, 1'b1, 8'h00, 8'h00, 8'h00);
    send_tick(1'b1, KeyShiftLock, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_tick(1'b1, 8'h40, 1'b1, 8'h12, 8'h34, 8'h56);
    set_effect(MODE_OFF, 5'd0, 5'd0, 2'd0);
    send_tick(1'b1, KeyShiftLock, 1'b1, 8'hFF, 8'h00, 8'hFF);
    send_tick(1'b0, KeyShiftLock, 1'b1, 8'h00, 8'hFF, 8'h00);
    set_effect(MODE_FIXED, 5'd31, 5'd24, 2'd3);
    send_tick(1'b0, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00);
    set_effect(MODE_FIXED, 5'd31, 5'd31, 2'd1);
    send_tick(1'b1, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
    set_effect(MODE_FIXED, 5'd1, 5'd25, 2'd2);
    send_tick(1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
    set_effect(MODE_SID, 5'd31, 5'd0, 2'd0);
    send_tick(1'b0, 8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_tick(1'b1, KeyShiftLock, 1'b1, 8'h00, 8'h00, 8'h00);
    send_tick(1'b0, 8'h00, 1'b0, 8'hA5, 8'h5A, 8'h0F);
    set_effect(MODE_SPARKLE, 5'd31, 5'd0, 2'd3);
    repeat (6) random_tick();
    set_effect(3'd5, 5'd3, 5'd3, 2'd0);
    send_tick(1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
    set_effect(3'd7, 5'd3, 5'd3, 2'd0);
    send_tick(1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);

    set_effect(MODE_SPARKLE, 5'd17, 5'd0, 2'd0);
    repeat (60) random_tick();
    set_effect(MODE_RAINBOW, 5'd31, 5'd0, 2'd2);
    repeat (40) random_tick();
    for (int p = 0; p < 8; p++) begin
      set_effect(($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4)),
                 5'($urandom), 5'($urandom_range(0, 31)), 2'($urandom));
      n = $urandom_range(20, 40);
      repeat (n) random_tick();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
